>>> design/crs_pkg.sv
`default_nettype none

package crs_pkg;

   localparam int COORD_W = 16;
   localparam int SIZE_W = 15;
   localparam int DEFAULT_STACK_DEPTH = 16;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_POP_EMPTY  = 2'd1,
      STATUS_PUSH_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [SIZE_W-1:0]         w;
      logic [SIZE_W-1:0]         h;
   } rect_type;

   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

endpackage

`default_nettype wire

>>> design/crs_channels.sv
`default_nettype none

interface crs_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic signed [crs_pkg::COORD_W-1:0]  rect_x;
   logic signed [crs_pkg::COORD_W-1:0]  rect_y;
   logic [crs_pkg::SIZE_W-1:0]          rect_width;
   logic [crs_pkg::SIZE_W-1:0]          rect_height;

   modport source (output valid, func, rect_x, rect_y, rect_width, rect_height,
                   input ready);
   modport sink (input valid, func, rect_x, rect_y, rect_width, rect_height,
                 output ready);
endinterface

interface crs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [crs_pkg::COORD_W-1:0]  top_x;
   logic signed [crs_pkg::COORD_W-1:0]  top_y;
   logic [crs_pkg::SIZE_W-1:0]          top_width;
   logic [crs_pkg::SIZE_W-1:0]          top_height;
   logic                                nonempty;
   logic [1:0]                          status;

   modport source (output valid, top_x, top_y, top_width, top_height, nonempty, status,
                   input ready);
   modport sink (input valid, top_x, top_y, top_width, top_height, nonempty, status,
                 output ready);
endinterface

`default_nettype wire

>>> design/crs_isect.sv
`default_nettype none

module crs_isect (
   input  wire crs_pkg::rect_type top_rect,
   input  wire crs_pkg::rect_type new_rect,
   input  wire                    stack_empty,
   output crs_pkg::rect_type      out_rect
);

   localparam int EXT_W = crs_pkg::COORD_W + 2;

   logic signed [EXT_W-1:0] top_l;
   logic signed [EXT_W-1:0] top_t;
   logic signed [EXT_W-1:0] top_r;
   logic signed [EXT_W-1:0] top_b;
   logic signed [EXT_W-1:0] new_l;
   logic signed [EXT_W-1:0] new_t;
   logic signed [EXT_W-1:0] new_r;
   logic signed [EXT_W-1:0] new_b;
   logic signed [EXT_W-1:0] left;
   logic signed [EXT_W-1:0] upper;
   logic signed [EXT_W-1:0] right;
   logic signed [EXT_W-1:0] lower;
   logic signed [EXT_W-1:0] span_w;
   logic signed [EXT_W-1:0] span_h;

   assign top_l = EXT_W'(top_rect.x);
   assign top_t = EXT_W'(top_rect.y);
   assign new_l = EXT_W'(new_rect.x);
   assign new_t = EXT_W'(new_rect.y);
   assign top_r = top_l + $signed({3'b000, top_rect.w});
   assign top_b = top_t + $signed({3'b000, top_rect.h});
   assign new_r = new_l + $signed({3'b000, new_rect.w});
   assign new_b = new_t + $signed({3'b000, new_rect.h});

   assign left  = (top_l > new_l) ? top_l : new_l;
   assign upper = (top_t > new_t) ? top_t : new_t;
   assign right = (top_r < new_r) ? top_r : new_r;
   assign lower = (top_b < new_b) ? top_b : new_b;

   assign span_w = right - left;
   assign span_h = lower - upper;

   always_comb begin
      if (stack_empty) begin
         out_rect = new_rect;
      end else begin
         out_rect.x = left[crs_pkg::COORD_W-1:0];
         out_rect.y = upper[crs_pkg::COORD_W-1:0];
         out_rect.w = span_w[EXT_W-1] ? '0 : span_w[crs_pkg::SIZE_W-1:0];
         out_rect.h = span_h[EXT_W-1] ? '0 : span_h[crs_pkg::SIZE_W-1:0];
      end
   end

endmodule

`default_nettype wire

>>> design/crs_cell.sv
`default_nettype none

module crs_cell (
   input  wire                     clock,
   input  wire crs_pkg::shift_type shift,
   input  wire crs_pkg::rect_type  from_above,
   input  wire crs_pkg::rect_type  from_below,
   output crs_pkg::rect_type       rect_q
);

   crs_pkg::rect_type rect_ff;
   crs_pkg::rect_type rect_in;

   always_comb begin
      priority if (shift.push) begin
         rect_in = from_above;
      end else if (shift.pop) begin
         rect_in = from_below;
      end else begin
         rect_in = rect_ff;
      end
   end

   always_ff @(posedge clock) begin
      rect_ff <= rect_in;
   end

   assign rect_q = rect_ff;

endmodule

`default_nettype wire

>>> design/clip_rect_stack_top.sv
`default_nettype none

// Clip rectangle stack. Takes one push or pop per cycle and returns one
// registered result per transfer, in the cycle after the request transfer; a
// request is taken while the result register is empty or being drained. The
// entries sit in a chain of STACK_DEPTH cells, the top in the first cell: a
// push moves every entry one cell down and loads the intersected rectangle
// into the first cell, a pop moves every entry one cell up. The intersection
// with the current top is worked out in the same cycle in front of the first
// cell, so the clock period is set by that add, compare and clamp.
module clip_rect_stack_top #(
   parameter int STACK_DEPTH = crs_pkg::DEFAULT_STACK_DEPTH
) (
   input  wire        clock,
   input  wire        reset,
   crs_req_if.sink    req_chan,
   crs_rsp_if.source  rsp_chan
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   crs_pkg::rect_type       rsp_rect_ff;
   crs_pkg::rect_type       rsp_rect_in;
   logic                    rsp_nonempty_ff;
   logic                    rsp_nonempty_in;
   crs_pkg::status_type     rsp_status_ff;
   crs_pkg::status_type     rsp_status_in;

   logic                    req_accept;
   logic                    stack_empty;
   logic                    stack_full;
   logic                    is_push;
   logic                    push_ok;
   logic                    pop_ok;
   crs_pkg::shift_type      shift;
   crs_pkg::rect_type       new_rect;
   crs_pkg::rect_type       isect_rect;
   crs_pkg::rect_type       cell_q [STACK_DEPTH];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept = req_chan.valid && req_chan.ready;

   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign is_push     = (req_chan.func == crs_pkg::FUNC_PUSH);
   assign push_ok     = req_accept && is_push && !stack_full;
   assign pop_ok      = req_accept && !is_push && !stack_empty;

   assign shift.push = push_ok;
   assign shift.pop  = pop_ok;

   assign new_rect.x = req_chan.rect_x;
   assign new_rect.y = req_chan.rect_y;
   assign new_rect.w = req_chan.rect_width;
   assign new_rect.h = req_chan.rect_height;

   crs_isect u_isect (
      .top_rect    (cell_q[0]),
      .new_rect    (new_rect),
      .stack_empty (stack_empty),
      .out_rect    (isect_rect)
   );

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      crs_pkg::rect_type above;
      crs_pkg::rect_type below;

      if (i == 0) begin : g_first
         assign above = isect_rect;
      end else begin : g_inner
         assign above = cell_q[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = cell_q[i];
      end else begin : g_upper
         assign below = cell_q[i+1];
      end

      crs_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_above (above),
         .from_below (below),
         .rect_q     (cell_q[i])
      );
   end

   always_comb begin
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_rect_in     = rsp_rect_ff;
      rsp_nonempty_in = rsp_nonempty_ff;
      rsp_status_in   = rsp_status_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         priority if (push_ok) begin
            count_in        = count_ff + CNT_W'(1);
            rsp_rect_in     = isect_rect;
            rsp_nonempty_in = 1'b1;
            rsp_status_in   = crs_pkg::STATUS_OK;
         end else if (pop_ok) begin
            count_in        = count_ff - CNT_W'(1);
            rsp_nonempty_in = (count_ff != CNT_W'(1));
            rsp_rect_in     = (count_ff != CNT_W'(1)) ? cell_q[1] : '0;
            rsp_status_in   = crs_pkg::STATUS_OK;
         end else if (is_push) begin
            rsp_rect_in     = cell_q[0];
            rsp_nonempty_in = 1'b1;
            rsp_status_in   = crs_pkg::STATUS_PUSH_FULL;
         end else begin
            rsp_rect_in     = '0;
            rsp_nonempty_in = 1'b0;
            rsp_status_in   = crs_pkg::STATUS_POP_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rect_ff     <= rsp_rect_in;
      rsp_nonempty_ff <= rsp_nonempty_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.top_x      = rsp_rect_ff.x;
   assign rsp_chan.top_y      = rsp_rect_ff.y;
   assign rsp_chan.top_width  = rsp_rect_ff.w;
   assign rsp_chan.top_height = rsp_rect_ff.h;
   assign rsp_chan.nonempty   = rsp_nonempty_ff;
   assign rsp_chan.status     = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("entry count beyond stack depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push_ok |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("accepted push did not add an entry");

   a_nonempty_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(reset) && $past(req_accept)
         |-> rsp_nonempty_ff == (count_ff != '0))
      else $error("result nonempty flag disagrees with entry count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_push && stack_full
         |=> rsp_status_ff == crs_pkg::STATUS_PUSH_FULL && count_ff == $past(count_ff))
      else $error("push on full stack not flagged or not dropped");

endmodule

`default_nettype wire
